// File: design/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg: shared types and constants of the maze carver
// Event codes, action and direction codes, the result record and the
// control record that drives the path stack.
// ----------------------------------------------------------------------------
package dmc_pkg;

    // Default grid bound and reset value of the side register
    localparam int DEFAULT_MAX_SIDE = 16;
    localparam logic [4:0] SIDE_RESET = 5'd8;

    // Actions carried by an input transaction
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Walk directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Result events
    typedef enum logic [2:0] {
        EV_CARVED    = 3'd0,
        EV_BACKTRACK = 3'd1,
        EV_REJECT    = 3'd2,
        EV_IDLE      = 3'd3,
        EV_STARTED   = 3'd4
    } event_t;

    // One result record
    typedef struct packed {
        event_t     event_res;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic [1:0] direction;
        logic       finished;
    } result_t;

    // Commands to the path stack
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

// File: design/dmc_path_stack.sv
// ----------------------------------------------------------------------------
// dmc_path_stack: stack of carved directions
// The top entry lives in a register; the entries below it live in a memory
// whose registered read port always prefetches the entry that a pop would
// expose next, so a pop takes the new top straight from the prefetch register.
// ----------------------------------------------------------------------------
module dmc_path_stack
    import dmc_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_SIDE * DEFAULT_MAX_SIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  stack_ctrl_t ctrl,
    input  logic [1:0]  push_dir,
    output logic [1:0]  top_dir,
    output logic        empty
);

    localparam int DW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [1:0]    mem [DEPTH];
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [1:0]    top_reg;
    logic [1:0]    rd_data_reg;
    logic          full;
    logic          do_push;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign full    = (depth_reg == DW'(DEPTH));
    assign empty   = (depth_reg == '0);
    assign top_dir = top_reg;
    assign do_push = ctrl.push && !full;

    // The old top moves into the memory when a new entry is pushed.
    assign wr_en   = do_push && !empty;
    assign wr_addr = AW'(depth_reg - DW'(1));

    // Depth update.
    always_comb
    begin
        depth_next = depth_reg;
        if (ctrl.clear)
        begin
            depth_next = '0;
        end
        else if (do_push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (ctrl.pop && !empty)
        begin
            depth_next = depth_reg - DW'(1);
        end
    end

    // Prefetch the entry just below the next top.
    assign rd_addr = AW'(depth_next - DW'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // Memory, prefetch register and top register hold payload only.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= top_reg;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (!ctrl.clear)
        begin
            if (do_push)
            begin
                top_reg <= push_dir;
            end
            else if (ctrl.pop && !empty)
            begin
                top_reg <= rd_data_reg;
            end
        end
    end

endmodule

// File: design/dfs_maze_carver.sv
// ----------------------------------------------------------------------------
// dfs_maze_carver: randomized depth-first maze carver with backtracking
// Each result is registered in an output register, with a skid stage behind it.
// Throughput: one transaction per cycle while the skid stage is empty; the visited
// map sits in flip-flops and the four neighbour probes, the stack push or pop and
// the map update all complete in the same cycle.
// Reset: the visited map clears at once, the side register returns to 8 and
// no walk is running; the block accepts transactions right after reset.
// ----------------------------------------------------------------------------
module dfs_maze_carver
    import dmc_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [3:0] start_row,
    input  logic [3:0] start_col,
    input  logic [1:0] random_dir,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [3:0] cell_row,
    output logic [3:0] cell_col,
    output logic [1:0] direction,
    output logic       finished
);

    localparam int MAP_CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CW        = $clog2(MAX_SIDE);
    localparam int IW        = $clog2(MAP_CELLS);
    localparam int VW        = $clog2(MAP_CELLS + 1);
    localparam int SDW       = $clog2(MAX_SIDE + 1);
    localparam int SXW       = (SDW > 5) ? SDW : 5;
    localparam int CXW       = 2 * SXW;

    // Map index of a cell.
    function automatic logic [IW-1:0] cell_index(input logic [SXW-1:0] r,
                                                 input logic [SXW-1:0] c);
        return IW'(32'(r) * MAX_SIDE + 32'(c));
    endfunction

    // State.
    logic [4:0]           side_reg;
    logic [MAP_CELLS-1:0] visited_reg;
    logic [MAP_CELLS-1:0] visited_next;
    logic [CW-1:0]        row_reg;
    logic [CW-1:0]        row_next;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [VW-1:0]        visit_cnt_reg;
    logic [VW-1:0]        visit_cnt_next;
    logic                 active_reg;
    logic                 active_next;

    // Output register and skid stage.
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    result_t res;

    // Stack interface.
    stack_ctrl_t stk_ctrl;
    logic [1:0]  stk_top;
    logic        stk_empty;

    // Derived values.
    logic             accept;
    logic             out_free;
    logic [SXW-1:0]   eff_side;
    logic [SXW-1:0]   side_x;
    logic [CXW-1:0]   cells;
    logic [SXW-1:0]   row_x;
    logic [SXW-1:0]   col_x;
    logic [SXW-1:0]   srow_x;
    logic [SXW-1:0]   scol_x;
    logic [SXW-1:0]   nr [4];
    logic [SXW-1:0]   nc [4];
    logic [3:0]       bnd_ok;
    logic [3:0]       open;
    logic             any_open;
    logic [1:0]       bk_dir;
    logic [CXW-1:0]   visit_inc;

    assign accept   = in_valid && in_ready;
    assign in_ready = !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    // Effective side: zero counts as one, large values saturate.
    assign side_x = SXW'(side_reg);
    always_comb
    begin
        if (side_reg == '0)
        begin
            eff_side = SXW'(1);
        end
        else if (side_x > SXW'(MAX_SIDE))
        begin
            eff_side = SXW'(MAX_SIDE);
        end
        else
        begin
            eff_side = side_x;
        end
    end

    assign cells     = CXW'(eff_side) * CXW'(eff_side);
    assign row_x     = SXW'(row_reg);
    assign col_x     = SXW'(col_reg);
    assign visit_inc = CXW'(visit_cnt_reg) + CXW'(1);

    // Start cell saturated into the maze.
    assign srow_x = (SXW'(start_row) > eff_side - SXW'(1)) ? eff_side - SXW'(1)
                                                          : SXW'(start_row);
    assign scol_x = (SXW'(start_col) > eff_side - SXW'(1)) ? eff_side - SXW'(1)
                                                          : SXW'(start_col);

    // Probe the four neighbours of the current cell.
    always_comb
    begin
        for (int d = 0; d < 4; d++)
        begin
            nr[d]     = row_x;
            nc[d]     = col_x;
            bnd_ok[d] = 1'b1;
            case (2'(d))
                DIR_UP:
                begin
                    bnd_ok[d] = (row_x != '0);
                    nr[d]     = row_x - SXW'(1);
                end
                DIR_DOWN:  nr[d] = row_x + SXW'(1);
                DIR_LEFT:
                begin
                    bnd_ok[d] = (col_x != '0);
                    nc[d]     = col_x - SXW'(1);
                end
                default:   nc[d] = col_x + SXW'(1);
            endcase
            open[d] = bnd_ok[d] && (nr[d] < eff_side) && (nc[d] < eff_side)
                      && !visited_reg[cell_index(nr[d], nc[d])];
        end
    end

    assign any_open = |open;
    assign bk_dir   = stk_top ^ DIR_DOWN;

    // Walk step.
    always_comb
    begin
        visited_next   = visited_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        visit_cnt_next = visit_cnt_reg;
        active_next    = active_reg;
        stk_ctrl       = '0;
        res.event_res  = EV_IDLE;
        res.direction  = DIR_UP;

        if (accept)
        begin
            if (action == ACT_START)
            begin
                visited_next = '0;
                visited_next[cell_index(srow_x, scol_x)] = 1'b1;
                row_next       = CW'(srow_x);
                col_next       = CW'(scol_x);
                visit_cnt_next = VW'(1);
                active_next    = (cells > CXW'(1));
                stk_ctrl.clear = 1'b1;
                res.event_res  = EV_STARTED;
            end
            else if (!active_reg)
            begin
                res.event_res = EV_IDLE;
            end
            else if (!any_open)
            begin
                if (stk_empty)
                begin
                    active_next   = 1'b0;
                    res.event_res = EV_IDLE;
                end
                else
                begin
                    // Step back against the pushed direction within the grid bound.
                    stk_ctrl.pop  = 1'b1;
                    res.event_res = EV_BACKTRACK;
                    case (bk_dir)
                        DIR_UP:
                        begin
                            if (row_x != '0)
                            begin
                                row_next = row_reg - CW'(1);
                            end
                        end
                        DIR_DOWN:
                        begin
                            if (row_x + SXW'(1) < SXW'(MAX_SIDE))
                            begin
                                row_next = row_reg + CW'(1);
                            end
                        end
                        DIR_LEFT:
                        begin
                            if (col_x != '0)
                            begin
                                col_next = col_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            if (col_x + SXW'(1) < SXW'(MAX_SIDE))
                            begin
                                col_next = col_reg + CW'(1);
                            end
                        end
                    endcase
                end
            end
            else if (!open[random_dir])
            begin
                res.event_res = EV_REJECT;
            end
            else
            begin
                // Carve into the drawn neighbour.
                row_next = CW'(nr[random_dir]);
                col_next = CW'(nc[random_dir]);
                visited_next[cell_index(nr[random_dir], nc[random_dir])] = 1'b1;
                visit_cnt_next = VW'(visit_inc);
                stk_ctrl.push  = 1'b1;
                if (visit_inc >= cells)
                begin
                    active_next = 1'b0;
                end
                res.event_res = EV_CARVED;
                res.direction = random_dir;
            end
        end

        res.cell_row = 4'(row_next);
        res.cell_col = 4'(col_next);
        res.finished = !active_next;
    end

    dmc_path_stack #(
        .DEPTH (MAP_CELLS)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (stk_ctrl),
        .push_dir (random_dir),
        .top_dir  (stk_top),
        .empty    (stk_empty)
    );

    // Control state, visited map and output valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg       <= SIDE_RESET;
            visited_reg    <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            visit_cnt_reg  <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                side_reg <= cfg_wdata;
            end
            visited_reg   <= visited_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            visit_cnt_reg <= visit_cnt_next;
            active_reg    <= active_next;
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = out_reg.event_res;
    assign cell_row  = out_reg.cell_row;
    assign cell_col  = out_reg.cell_col;
    assign direction = out_reg.direction;
    assign finished  = out_reg.finished;

    // A held result in the skid stage always has one ahead of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output is empty");

    // A start leaves an empty stack and exactly one visited cell counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_START)) |=> (stk_empty && (visit_cnt_reg == VW'(1))))
        else $error("start did not reset the walk");

    // While a walk runs, the cell it stands on is marked visited.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> visited_reg[cell_index(row_x, col_x)])
        else $error("walk stands on an unvisited cell");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the depth-first maze carver
// A scoreboard predicts every result from its own copy of the visited map,
// the path stack and the walk position. Directed walks cover the corner cases,
// and random walks steer toward open cells to reach deep into large mazes.
// Both sides of the handshake idle in random bursts, except in the final part.
// ----------------------------------------------------------------------------
module tb;
    import dmc_pkg::*;

    localparam int GRID  = DEFAULT_MAX_SIDE;
    localparam int CELLS = GRID * GRID;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [4:0] cfg_wdata  = '0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic       action     = ACT_STEP;
    logic [3:0] start_row  = '0;
    logic [3:0] start_col  = '0;
    logic [1:0] random_dir = DIR_UP;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [2:0] event_res;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic [1:0] direction;
    logic       finished;

    // Scoreboard copy of the carver state
    bit          visited [CELLS];
    logic [1:0]  stack_dirs [CELLS];
    int unsigned stack_top    = 0;
    int unsigned cur_r        = 0;
    int unsigned cur_c        = 0;
    int unsigned cells_seen   = 0;
    bit          walk_running = 1'b0;
    logic [4:0]  side_reg     = SIDE_RESET;

    result_t pending_moves [$];
    int      mismatches = 0;
    int      busy_items = 0;
    bit      gaps_on    = 1'b1;
    int      stall_left = 0;

    dfs_maze_carver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .start_row  (start_row),
        .start_col  (start_col),
        .random_dir (random_dir),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .direction  (direction),
        .finished   (finished)
    );

    always #4 clk = ~clk;

    // The side register in force: zero counts as one, large values saturate.
    function automatic int unsigned clamp_side();
        int unsigned s;
        s = side_reg;
        if (s < 1) s = 1;
        if (s > GRID) s = GRID;
        return s;
    endfunction

    // Neighbor of (r, c) in direction d; false when it leaves a bound x bound grid.
    function automatic bit move_cell(input int unsigned r, input int unsigned c,
                                     input logic [1:0] d, input int unsigned bound,
                                     output int unsigned nr, output int unsigned nc);
        nr = r;
        nc = c;
        case (d)
            DIR_UP:
            begin
                if (r == 0) return 1'b0;
                nr = r - 1;
            end
            DIR_DOWN: nr = r + 1;
            DIR_LEFT:
            begin
                if (c == 0) return 1'b0;
                nc = c - 1;
            end
            default: nc = c + 1;
        endcase
        return (nr < bound) && (nc < bound);
    endfunction

    // True when direction d leads to an unvisited cell inside the maze.
    function automatic bit cell_free(input int unsigned r, input int unsigned c,
                                     input logic [1:0] d, input int unsigned side);
        int unsigned nr;
        int unsigned nc;
        if (!move_cell(r, c, d, side, nr, nc)) return 1'b0;
        return !visited[nr * GRID + nc];
    endfunction

    // Advance the scoreboard state by one transaction and return its result.
    function automatic result_t predict_move(input logic act, input logic [3:0] row_in,
                                             input logic [3:0] col_in,
                                             input logic [1:0] dir_in);
        int unsigned side;
        int unsigned cells;
        int unsigned nr;
        int unsigned nc;
        logic [1:0]  d;
        bit          any_open;
        result_t     res;
        side      = clamp_side();
        cells     = side * side;
        any_open  = 1'b0;
        // Direction reads zero unless a cell was carved.
        res.direction = DIR_UP;
        if (act == ACT_START)
        begin
            nr = row_in;
            nc = col_in;
            if (nr > side - 1) nr = side - 1;
            if (nc > side - 1) nc = side - 1;
            foreach (visited[i]) visited[i] = 1'b0;
            stack_top  = 0;
            cur_r      = nr;
            cur_c      = nc;
            visited[nr * GRID + nc] = 1'b1;
            cells_seen = 1;
            walk_running = cells_seen < cells;
            res.event_res = EV_STARTED;
        end
        else if (!walk_running)
        begin
            res.event_res = EV_IDLE;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                if (cell_free(cur_r, cur_c, 2'(k), side)) any_open = 1'b1;
            if (!any_open)
            begin
                if (stack_top == 0)
                begin
                    walk_running  = 1'b0;
                    res.event_res = EV_IDLE;
                end
                else
                begin
                    // Step back against the direction that brought the walk here.
                    stack_top--;
                    d = stack_dirs[stack_top];
                    if (move_cell(cur_r, cur_c, d ^ 2'b01, GRID, nr, nc))
                    begin
                        cur_r = nr;
                        cur_c = nc;
                    end
                    res.event_res = EV_BACKTRACK;
                end
            end
            else if (!cell_free(cur_r, cur_c, dir_in, side))
            begin
                res.event_res = EV_REJECT;
            end
            else
            begin
                void'(move_cell(cur_r, cur_c, dir_in, side, nr, nc));
                cur_r = nr;
                cur_c = nc;
                visited[nr * GRID + nc] = 1'b1;
                cells_seen++;
                stack_dirs[stack_top] = dir_in;
                stack_top++;
                if (cells_seen >= cells) walk_running = 1'b0;
                res.event_res = EV_CARVED;
                res.direction = dir_in;
            end
        end
        res.cell_row = cur_r[3:0];
        res.cell_col = cur_c[3:0];
        res.finished = !walk_running;
        return res;
    endfunction

    // Send one transaction, with an optional random gap in front of it.
    task automatic send_item(input logic act, input logic [3:0] row, input logic [3:0] col,
                             input logic [1:0] dir);
        result_t res;
        int      gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= act;
        start_row  <= row;
        start_col  <= col;
        random_dir <= dir;
        do @(posedge clk); while (!in_ready);
        res = predict_move(act, row, col, dir);
        pending_moves.push_back(res);
        if (res.event_res != EV_IDLE) busy_items++;
    endtask

    // Hold the sender until every predicted result has been checked.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write the side register once the carver is idle.
    task automatic write_side(input logic [4:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        side_reg = value;
    endtask

    // Random walks: steered toward open cells, with noise and mid-walk side changes.
    task automatic run_walks(input int budget, input bit allow_gaps);
        int         goal;
        int         steps;
        int         cap;
        int         pick;
        logic [1:0] dir;
        logic [1:0] open_dirs [$];
        goal = busy_items + budget;
        while (busy_items < goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12) write_side(5'($urandom_range(2, 6)));
            else if (pick < 14) write_side(5'($urandom_range(0, 1)));
            else if (pick < 17) write_side(5'($urandom_range(7, 12)));
            else if (pick < 19) write_side(5'(GRID));
            else write_side(5'($urandom_range(17, 31)));
            gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            cap = (clamp_side() > 8) ? $urandom_range(40, 250) : 2000;
            send_item(ACT_START, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
            steps = 0;
            while (walk_running && steps < cap && busy_items < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick == 0) write_side(5'($urandom_range(0, 17)));
                if (pick == 1)
                begin
                    // Broken sequence: any action, possibly a restart mid-walk.
                    send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
                end
                else
                begin
                    open_dirs.delete();
                    for (int k = 0; k < 4; k++)
                        if (cell_free(cur_r, cur_c, 2'(k), clamp_side()))
                            open_dirs.push_back(2'(k));
                    dir = 2'($urandom_range(0, 3));
                    if (open_dirs.size() != 0 && $urandom_range(0, 3) != 0)
                        dir = open_dirs[$urandom_range(0, open_dirs.size() - 1)];
                    send_item(ACT_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              dir);
                end
                steps++;
            end
            // A few steps past the end of the walk.
            repeat ($urandom_range(0, 2))
                send_item(ACT_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          2'($urandom_range(0, 3)));
        end
    endtask

    // Steps with no walk running after reset report idle.
    task automatic test_step_without_walk();
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_UP);
        send_item(ACT_STEP, 4'd15, 4'd15, DIR_RIGHT);
    endtask

    // A one-cell maze finishes on start; a zero side counts as one.
    task automatic test_single_cell();
        write_side(5'd0);
        send_item(ACT_START, 4'd15, 4'd15, DIR_DOWN);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_DOWN);
        write_side(5'd1);
        send_item(ACT_START, 4'd0, 4'd0, DIR_UP);
        send_item(ACT_STEP, 4'd15, 4'd15, DIR_RIGHT);
    endtask

    // Start cells outside the maze clamp; an oversized side saturates.
    task automatic test_start_clamp();
        write_side(5'd4);
        send_item(ACT_START, 4'd15, 4'd15, DIR_UP);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_DOWN);
        write_side(5'd31);
        send_item(ACT_START, 4'd15, 4'd0, DIR_LEFT);
        send_item(ACT_STEP, 4'd0, 4'd15, DIR_UP);
        send_item(ACT_STEP, 4'd15, 4'd0, DIR_RIGHT);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_DOWN);
        send_item(ACT_STEP, 4'd15, 4'd15, DIR_LEFT);
    endtask

    // Shrinking the side mid-walk strands cells: the walk backtracks to an
    // empty stack and ends there.
    task automatic test_dead_end_empty_stack();
        write_side(5'd2);
        send_item(ACT_START, 4'd0, 4'd0, DIR_UP);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_RIGHT);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_DOWN);
        write_side(5'd1);
        repeat (4) send_item(ACT_STEP, 4'd0, 4'd0, DIR_UP);
    endtask

    // One step in each direction after a start at the center of a small maze, carved or rejected.
    task automatic test_every_direction();
        write_side(5'd3);
        send_item(ACT_START, 4'd1, 4'd1, DIR_UP);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_UP);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_DOWN);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_LEFT);
        send_item(ACT_STEP, 4'd0, 4'd0, DIR_RIGHT);
    endtask

    // Random walks with bursty idling on both sides.
    task automatic test_random_walks();
        run_walks(680, 1'b1);
    endtask

    // Final stretch: back-to-back transactions with no random idling on either side.
    task automatic test_back_to_back();
        run_walks(120, 1'b0);
    endtask

    // Receiver stalls in random bursts while gaps are on.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare every result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_moves.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result ev=%0d row=%0d col=%0d dir=%0d fin=%0d",
                             $time, event_res, cell_row, cell_col, direction, finished);
                mismatches++;
            end
            else
            begin
                want = pending_moves.pop_front();
                if (event_res !== want.event_res || cell_row !== want.cell_row ||
                    cell_col !== want.cell_col || direction !== want.direction ||
                    finished !== want.finished)
                begin
                    if (mismatches < 10)
                        $display("%0t: mismatch expected ev=%0d row=%0d col=%0d dir=%0d fin=%0d, got ev=%0d row=%0d col=%0d dir=%0d fin=%0d",
                                 $time, want.event_res, want.cell_row, want.cell_col,
                                 want.direction, want.finished, event_res, cell_row,
                                 cell_col, direction, finished);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_step_without_walk();
        test_single_cell();
        test_start_clamp();
        test_dead_end_empty_stack();
        test_every_direction();
        test_random_walks();
        test_back_to_back();
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending_moves.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(4_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
design/dmc_pkg.sv
design/dmc_path_stack.sv
design/dfs_maze_carver.sv
verif/tb.sv
